// ===== hw/rtl/sicf_pkg.sv =====
// Shared types and constants of the stencil id cleanup filter.
// No dependencies; every other file of the block but sicf_ram uses this package.
`default_nettype none

package sicf_pkg;

    // One input beat: pixel color plus the drain marker.
    typedef struct packed {
        logic [7:0] red_level;
        logic [7:0] green_level;
        logic [7:0] blue_level;
        logic       pixel_present;
    } t_pixel;

    // One output beat.
    typedef struct packed {
        logic [7:0]  stencil_id;
        logic        frame_last;
        logic [20:0] nonzero_count;
    } t_result;

    // Per-item control that travels down the pipeline next to the data.
    typedef struct packed {
        logic       valid;       // stage holds an item that advanced the frame
        logic       ja;          // id phase running (an id column is produced)
        logic       kv;          // this item yields a result
        logic       interior;    // result pixel is inside the one-pixel border
        logic       tiny_frame;  // width or height below three: filters off
        logic       last;        // result is the final one of the frame
        logic [4:0] row_mask;    // rows yi..yi-4 of the 5-tall column lie in frame
        logic [4:0] col_mask;    // window column of age 0..4 lies in the row
    } t_ctl;

    localparam logic        REG_WIDTH     = 1'b0;
    localparam logic        REG_HEIGHT    = 1'b1;
    localparam logic [10:0] RESET_WIDTH   = 11'd640;
    localparam logic [10:0] RESET_HEIGHT  = 11'd480;
    localparam logic [20:0] NZ_MAX        = 21'h1FFFFF;
    localparam logic [7:0]  CLOSE_LIMIT   = 8'd2;
    localparam logic [3:0]  VOTE_MIN      = 4'd4;

endpackage

`default_nettype wire

// ===== hw/rtl/sicf_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module sicf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0]      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/sicf_id_stage.sv =====
// RGB line memory, clipped 5x5 per-channel max and id decode (stages 1 and 2).
// Uses sicf_pkg and sicf_ram.
`default_nettype none

module sicf_id_stage #(
    parameter int MAX_WIDTH = 1024,
    localparam int AW = $clog2(MAX_WIDTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_adv,
    input  wire sicf_pkg::t_ctl   i_ctl,
    input  wire logic [23:0]      i_pix,
    input  wire logic [AW-1:0]    i_x,
    input  wire logic [AW-1:0]    i_xj,
    output sicf_pkg::t_ctl        o_s1_ctl,
    output logic [AW-1:0]         o_s1_xj,
    output sicf_pkg::t_ctl        o_s2_ctl,
    output logic [AW-1:0]         o_s2_xj,
    output logic [7:0]            o_s2_id
);

    sicf_pkg::t_ctl r_s1_ctl;
    sicf_pkg::t_ctl r_s2_ctl;
    logic [23:0]    r_s1_pix;
    logic [AW-1:0]  r_s1_x;
    logic [AW-1:0]  r_s1_xj;
    logic [AW-1:0]  r_s2_xj;
    logic           r_fwd;
    logic [95:0]    r_fwd_data;
    logic [23:0]    r_cmax [5];
    logic [23:0]    r_raw  [3];

    logic [95:0]    ram_rd;
    logic [95:0]    col_rd;
    logic [95:0]    col_wr;
    logic           col_we;
    logic [23:0]    rows [5];
    logic [23:0]    cmax;
    logic [23:0]    hmax;

    function automatic logic [7:0] f_decode(input logic [23:0] p);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] m;
        logic [7:0] drg;
        logic [7:0] drb;
        r   = p[23:16];
        g   = p[15:8];
        b   = p[7:0];
        drg = (r > g) ? r - g : g - r;
        drb = (r > b) ? r - b : b - r;
        m   = r;
        if (g > m) m = g;
        if (b > m) m = b;
        if (drg <= sicf_pkg::CLOSE_LIMIT && drb <= sicf_pkg::CLOSE_LIMIT) m = r;
        return m;
    endfunction

    sicf_ram #(.WIDTH(96), .DEPTH(MAX_WIDTH)) u_rgb_ram (
        .i_clk   (i_clk),
        .i_we    (col_we),
        .i_waddr (r_s1_x),
        .i_wdata (col_wr),
        .i_re    (i_ctl.valid),
        .i_raddr (i_x),
        .o_rdata (ram_rd)
    );

    // Stage 1: column of rows yi..yi-4 at this x, shift the stored rows down.
    assign col_rd = r_fwd ? r_fwd_data : ram_rd;
    assign col_we = i_adv && r_s1_ctl.valid;
    assign col_wr = {r_s1_pix, col_rd[95:24]};

    always_comb begin
        rows[0] = r_s1_pix;
        rows[1] = col_rd[95:72];
        rows[2] = col_rd[71:48];
        rows[3] = col_rd[47:24];
        rows[4] = col_rd[23:0];
        cmax = '0;
        for (int k = 0; k < 5; k++) begin
            for (int c = 0; c < 3; c++) begin
                if (r_s1_ctl.row_mask[k] && rows[k][c*8 +: 8] > cmax[c*8 +: 8]) begin
                    cmax[c*8 +: 8] = rows[k][c*8 +: 8];
                end
            end
        end
    end

    // Stage 2: horizontal max over the five newest columns, clipped by column.
    always_comb begin
        hmax = '0;
        for (int a = 0; a < 5; a++) begin
            for (int c = 0; c < 3; c++) begin
                if (r_s2_ctl.col_mask[a] && r_cmax[a][c*8 +: 8] > hmax[c*8 +: 8]) begin
                    hmax[c*8 +: 8] = r_cmax[a][c*8 +: 8];
                end
            end
        end
    end

    assign o_s2_id  = r_s2_ctl.tiny_frame ? f_decode(r_raw[2]) : f_decode(hmax);
    assign o_s1_ctl = r_s1_ctl;
    assign o_s1_xj  = r_s1_xj;
    assign o_s2_ctl = r_s2_ctl;
    assign o_s2_xj  = r_s2_xj;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
            r_s2_ctl <= '0;
            r_fwd    <= 1'b0;
        end else begin
            if (i_adv) begin
                r_s1_ctl <= i_ctl;
                r_s2_ctl <= r_s1_ctl;
            end
            // same column written while it is read: take the write data
            if (i_ctl.valid) begin
                r_fwd <= r_s1_ctl.valid && (r_s1_x == i_x);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s1_pix <= i_pix;
            r_s1_x   <= i_x;
            r_s1_xj  <= i_xj;
            r_s2_xj  <= r_s1_xj;
        end
        if (i_ctl.valid) begin
            r_fwd_data <= col_wr;
        end
        if (col_we) begin
            r_cmax[0] <= cmax;
            for (int a = 1; a < 5; a++) r_cmax[a] <= r_cmax[a-1];
            r_raw[0] <= rows[2];
            for (int a = 1; a < 3; a++) r_raw[a] <= r_raw[a-1];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sicf_mode_stage.sv =====
// Id line memory and 3x3 mode vote with centre fallback (stages 2 to 4).
// Uses sicf_pkg and sicf_ram.
`default_nettype none

module sicf_mode_stage #(
    parameter int MAX_WIDTH = 1024,
    localparam int AW = $clog2(MAX_WIDTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_adv,
    input  wire sicf_pkg::t_ctl   i_s1_ctl,
    input  wire logic [AW-1:0]    i_s1_xj,
    input  wire sicf_pkg::t_ctl   i_s2_ctl,
    input  wire logic [AW-1:0]    i_s2_xj,
    input  wire logic [7:0]       i_s2_id,
    output logic                  o_res_valid,
    output logic [7:0]            o_res_id,
    output logic                  o_res_last
);

    sicf_pkg::t_ctl r_s3_ctl;
    sicf_pkg::t_ctl r_s4_ctl;
    logic           r_fwd;
    logic [15:0]    r_fwd_data;
    logic [7:0]     r_top [3];
    logic [7:0]     r_mid [3];
    logic [7:0]     r_bot [3];
    logic [7:0]     r_s4_vals [9];
    logic [3:0]     r_s4_cnt  [9];

    logic           id_re;
    logic           id_we;
    logic [15:0]    ram_rd;
    logic [15:0]    col_rd;
    logic [15:0]    col_wr;
    logic [7:0]     vals [9];
    logic [3:0]     cnt  [9];
    logic [3:0]     best_cnt;
    logic [7:0]     best_val;

    assign id_re  = i_adv && i_s1_ctl.valid && i_s1_ctl.ja;
    assign id_we  = i_adv && i_s2_ctl.valid && i_s2_ctl.ja;
    assign col_rd = r_fwd ? r_fwd_data : ram_rd;
    assign col_wr = {i_s2_id, col_rd[15:8]};

    sicf_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_id_ram (
        .i_clk   (i_clk),
        .i_we    (id_we),
        .i_waddr (i_s2_xj),
        .i_wdata (col_wr),
        .i_re    (id_re),
        .i_raddr (i_s1_xj),
        .o_rdata (ram_rd)
    );

    // Stage 3: vote count of each window place, window in raster order.
    always_comb begin
        vals[0] = r_top[2]; vals[1] = r_top[1]; vals[2] = r_top[0];
        vals[3] = r_mid[2]; vals[4] = r_mid[1]; vals[5] = r_mid[0];
        vals[6] = r_bot[2]; vals[7] = r_bot[1]; vals[8] = r_bot[0];
        for (int p = 0; p < 9; p++) begin
            cnt[p] = '0;
            for (int q = 0; q < 9; q++) begin
                cnt[p] = cnt[p] + {3'b000, (vals[p] == vals[q])};
            end
        end
    end

    // Stage 4: earliest place with the top count wins.
    always_comb begin
        best_cnt = r_s4_cnt[0];
        best_val = r_s4_vals[0];
        for (int p = 1; p < 9; p++) begin
            if (r_s4_cnt[p] > best_cnt) begin
                best_cnt = r_s4_cnt[p];
                best_val = r_s4_vals[p];
            end
        end
    end

    assign o_res_valid = r_s4_ctl.valid && r_s4_ctl.kv;
    assign o_res_last  = r_s4_ctl.last;
    assign o_res_id    = (r_s4_ctl.interior && best_cnt >= sicf_pkg::VOTE_MIN) ?
                         best_val : r_s4_vals[4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_ctl <= '0;
            r_s4_ctl <= '0;
            r_fwd    <= 1'b0;
        end else begin
            if (i_adv) begin
                r_s3_ctl <= i_s2_ctl;
                r_s4_ctl <= r_s3_ctl;
            end
            if (id_re) begin
                r_fwd <= id_we && (i_s2_xj == i_s1_xj);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (id_re) begin
            r_fwd_data <= col_wr;
        end
        if (id_we) begin
            r_top[0] <= col_rd[7:0];
            r_mid[0] <= col_rd[15:8];
            r_bot[0] <= i_s2_id;
            for (int a = 1; a < 3; a++) begin
                r_top[a] <= r_top[a-1];
                r_mid[a] <= r_mid[a-1];
                r_bot[a] <= r_bot[a-1];
            end
        end
        if (i_adv) begin
            r_s4_vals <= vals;
            r_s4_cnt  <= cnt;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/stencil_id_cleanup_filter_unit.sv =====
// Top level of the stencil id cleanup filter: APB registers, frame counters,
// output register. Uses sicf_pkg, sicf_id_stage and sicf_mode_stage.
`default_nettype none

// Stencil id cleanup filter. Takes one RGB pixel beat per clock in raster
// order and returns one cleaned id beat per clock unless the output stalls:
// a clipped 5x5 max filter per channel, an id decode, then a 3x3 mode vote
// on interior pixels (four votes needed, earliest value wins ties). The
// result for pixel k comes out with the item that arrives 3*width+3 beats
// after it, so after the last pixel the source sends 3*width+3 drain beats
// (pixel_present low) to flush the tail; a drain beat inside the frame is
// taken and dropped. Items go through line memory read with column max,
// row max and decode, vote count and vote select to the output register;
// a new beat is taken every cycle while the output register is free or
// being emptied. Two line memories of MAX_WIDTH words (four RGB rows and
// two id rows) are read and written back once per item, the id memory only
// in the id phase; no clearing pass is needed after reset. The final result
// of a frame carries the count of nonzero ids. Write frame_width / frame_height
// (APB offsets 0x0 and 0x4) only between frames; a write restarts the frame.
module stencil_id_cleanup_filter_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire sicf_pkg::t_pixel  i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output sicf_pkg::t_result      o_out_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = AW + 2;
    localparam int HW = $clog2(MAX_HEIGHT) + 2;
    localparam int TW = $clog2(MAX_WIDTH * MAX_HEIGHT + 4 * MAX_WIDTH + 8);

    // configuration
    logic [10:0]       r_cfg_width;
    logic [10:0]       r_cfg_height;
    logic [WW-1:0]     w_cl;
    logic [HW-1:0]     h_cl;
    logic              cfg_wr;

    // frame position counters
    logic [TW-1:0]     r_t;
    logic [AW-1:0]     r_xi;
    logic [HW-1:0]     r_yi;
    logic [AW-1:0]     r_xj;
    logic [AW-1:0]     r_xk;
    logic [HW-1:0]     r_yk;

    // output side
    logic              r_out_valid;
    sicf_pkg::t_result r_out;
    logic [20:0]       r_nz;

    logic              adv;
    logic              take;
    logic              item;
    logic [TW-1:0]     lag_id;
    logic [TW-1:0]     lag_out;
    logic              ja;
    logic              ka;
    logic              kv;
    logic              last;
    logic [WW-1:0]     xi_inc;
    logic [WW-1:0]     xj_inc;
    logic [WW-1:0]     xk_inc;
    logic [WW-1:0]     xj_e;
    sicf_pkg::t_ctl    ctl;

    sicf_pkg::t_ctl    s1_ctl;
    sicf_pkg::t_ctl    s2_ctl;
    logic [AW-1:0]     s1_xj;
    logic [AW-1:0]     s2_xj;
    logic [7:0]        s2_id;
    logic              res_valid;
    logic [7:0]        res_id;
    logic              res_last;
    logic [20:0]       nz_next;

    // Clamp the programmed sizes into 1..MAX.
    always_comb begin
        if (r_cfg_width == 11'd0) begin
            w_cl = WW'(1);
        end else if (32'(r_cfg_width) > 32'(MAX_WIDTH)) begin
            w_cl = WW'(MAX_WIDTH);
        end else begin
            w_cl = WW'(r_cfg_width);
        end
        if (r_cfg_height == 11'd0) begin
            h_cl = HW'(1);
        end else if (32'(r_cfg_height) > 32'(MAX_HEIGHT)) begin
            h_cl = HW'(MAX_HEIGHT);
        end else begin
            h_cl = HW'(r_cfg_height);
        end
    end

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == sicf_pkg::REG_HEIGHT) ? {21'd0, r_cfg_height}
                                                       : {21'd0, r_cfg_width};

    // Hold the whole pipeline while the output beat waits.
    assign adv        = !r_out_valid || i_out_ready;
    assign o_in_ready = adv;
    assign take       = i_in_valid && adv;
    // A drain beat only counts once every pixel of the frame has arrived.
    assign item       = take && ((r_yi >= h_cl) || i_in_data.pixel_present);

    assign lag_id  = TW'({w_cl, 1'b0}) + TW'(2);
    assign lag_out = lag_id + TW'(w_cl) + TW'(1);
    assign ja      = r_t >= lag_id;
    assign ka      = r_t >= lag_out;
    assign kv      = ka && (r_yk < h_cl);
    assign xi_inc  = WW'(r_xi) + WW'(1);
    assign xj_inc  = WW'(r_xj) + WW'(1);
    assign xk_inc  = WW'(r_xk) + WW'(1);
    assign xj_e    = WW'(r_xj);
    assign last    = kv && (r_yk + HW'(1) == h_cl) && (xk_inc == w_cl);

    always_comb begin
        ctl            = '0;
        ctl.valid      = item;
        ctl.ja         = ja;
        ctl.kv         = kv;
        ctl.last       = last;
        ctl.tiny_frame = (w_cl < WW'(3)) || (h_cl < HW'(3));
        ctl.interior   = !ctl.tiny_frame && (r_yk != '0) && (r_xk != '0) &&
                         (r_yk + HW'(1) != h_cl) && (xk_inc != w_cl);
        for (int k = 0; k < 5; k++) begin
            ctl.row_mask[k] = (r_yi >= HW'(k)) && (r_yi < h_cl + HW'(k));
        end
        ctl.col_mask[0] = (xj_e + WW'(3)) <= w_cl;
        ctl.col_mask[1] = (xj_e + WW'(2)) <= w_cl;
        ctl.col_mask[2] = 1'b1;
        ctl.col_mask[3] = xj_e >= WW'(1);
        ctl.col_mask[4] = xj_e >= WW'(2);
    end

    sicf_id_stage #(.MAX_WIDTH(MAX_WIDTH)) u_id_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_ctl    (ctl),
        .i_pix    ({i_in_data.red_level, i_in_data.green_level, i_in_data.blue_level}),
        .i_x      (r_xi),
        .i_xj     (r_xj),
        .o_s1_ctl (s1_ctl),
        .o_s1_xj  (s1_xj),
        .o_s2_ctl (s2_ctl),
        .o_s2_xj  (s2_xj),
        .o_s2_id  (s2_id)
    );

    sicf_mode_stage #(.MAX_WIDTH(MAX_WIDTH)) u_mode_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_s1_ctl    (s1_ctl),
        .i_s1_xj     (s1_xj),
        .i_s2_ctl    (s2_ctl),
        .i_s2_xj     (s2_xj),
        .i_s2_id     (s2_id),
        .o_res_valid (res_valid),
        .o_res_id    (res_id),
        .o_res_last  (res_last)
    );

    // Saturating nonzero tally, including the beat being loaded.
    assign nz_next = (res_id != 8'd0 && r_nz != sicf_pkg::NZ_MAX) ? r_nz + 21'd1 : r_nz;

    // Registers, counters and frame restart.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= sicf_pkg::RESET_WIDTH;
            r_cfg_height <= sicf_pkg::RESET_HEIGHT;
            r_t          <= '0;
            r_xi         <= '0;
            r_yi         <= '0;
            r_xj         <= '0;
            r_xk         <= '0;
            r_yk         <= '0;
            r_out_valid  <= 1'b0;
            r_nz         <= '0;
        end else if (cfg_wr) begin
            if (paddr[2] == sicf_pkg::REG_HEIGHT) begin
                r_cfg_height <= pwdata[10:0];
            end else begin
                r_cfg_width  <= pwdata[10:0];
            end
            r_t  <= '0;
            r_xi <= '0;
            r_yi <= '0;
            r_xj <= '0;
            r_xk <= '0;
            r_yk <= '0;
            r_nz <= '0;
        end else begin
            if (item) begin
                if (last) begin
                    r_t  <= '0;
                    r_xi <= '0;
                    r_yi <= '0;
                    r_xj <= '0;
                    r_xk <= '0;
                    r_yk <= '0;
                end else begin
                    r_t <= r_t + TW'(1);
                    if (xi_inc == w_cl) begin
                        r_xi <= '0;
                        r_yi <= r_yi + HW'(1);
                    end else begin
                        r_xi <= xi_inc[AW-1:0];
                    end
                    if (ja) begin
                        r_xj <= (xj_inc == w_cl) ? '0 : xj_inc[AW-1:0];
                    end
                    if (kv) begin
                        if (xk_inc == w_cl) begin
                            r_xk <= '0;
                            r_yk <= r_yk + HW'(1);
                        end else begin
                            r_xk <= xk_inc[AW-1:0];
                        end
                    end
                end
            end
            if (adv) begin
                r_out_valid <= res_valid;
                if (res_valid) begin
                    r_nz <= res_last ? '0 : nz_next;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.stencil_id    <= res_id;
            r_out.frame_last    <= res_last;
            r_out.nonzero_count <= res_last ? nz_next : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    // input column stays inside the programmed row
    a_xi_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WW'(r_xi) < w_cl) else $error("input column beyond frame width");

    // result column stays inside the programmed row
    a_xk_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WW'(r_xk) < w_cl) else $error("result column beyond frame width");

    // a result is only due once ids are being produced
    a_kv_after_ja: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        kv |-> ja) else $error("result phase ahead of id phase");

    // the count rides only on the final beat of a frame
    a_count_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.frame_last) |-> (o_out_data.nonzero_count == 21'd0))
        else $error("nonzero count on a non-final beat");
`endif

endmodule

`default_nettype wire
